/* src/bleadv_pkg.sv */
// Shared types and constants for the BLE advertising filter with device table.
// Holds payload structs, table entry layout, opcodes and the controller/datapath links.
// No dependencies.
package bleadv_pkg;

   localparam int MAX_DEVICES_DEFAULT = 16;
   localparam int MAX_REPORT_BYTES    = 31;

   localparam logic [23:0] VENDOR_PREFIX_RESET = 24'h0025DF;
   localparam logic [15:0] SERVICE_UUID_RESET  = 16'hFE6C;

   // request opcodes
   localparam logic [1:0] OP_AD_BYTE      = 2'd0;
   localparam logic [1:0] OP_EMPTY_REPORT = 2'd1;
   localparam logic [1:0] OP_READ_ENTRY   = 2'd2;

   // result status codes
   localparam logic [2:0] RSP_NO_MATCH   = 3'd0;
   localparam logic [2:0] RSP_UPDATED    = 3'd1;
   localparam logic [2:0] RSP_ADDED      = 3'd2;
   localparam logic [2:0] RSP_TABLE_FULL = 3'd3;
   localparam logic [2:0] RSP_READ_DATA  = 3'd4;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         ad_byte;
      logic               last_byte;
      logic [47:0]        device_address;
      logic [1:0]         addr_kind;
      logic signed [7:0]  signal_level;
      logic [31:0]        now_tick;
      logic [3:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         entry_index;
      logic [4:0]         entry_count;
      logic [47:0]        entry_address;
      logic [1:0]         entry_addr_kind;
      logic signed [7:0]  entry_signal;
      logic [31:0]        added_tick;
      logic [31:0]        latest_tick;
      logic [31:0]        hits;
      logic               named;
   } rsp_type;

   // one device table row
   typedef struct packed {
      logic [47:0]        address;
      logic [1:0]         kind;
      logic signed [7:0]  signal;
      logic [31:0]        first;
      logic [31:0]        last;
      logic [31:0]        hits;
      logic               named;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic parse;       // walk one AD byte
      logic finish;      // capture report context, clear parse state, restart scan
      logic empty;       // report carries no AD bytes
      logic read_start;  // latch read index, fetch entry
      logic scan_step;   // fetch next table entry
      logic commit;      // apply decision, write table, load result
      logic read_done;   // load read result
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic decide;      // scan has reached its outcome
      logic out_free;    // result register can take a new item
   } dp_status_type;

endpackage

/* src/bleadv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bleadv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/bleadv_parse.sv */
// Length-type walker over the AD bytes of one advertising report.
// Depends on bleadv_pkg.
module bleadv_parse
   import bleadv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        clear,
   input  logic [7:0]  ad_byte,
   input  logic [15:0] service_uuid,
   output logic        report_match,
   output logic        report_named
);

   localparam logic [7:0] AD_UUID16_PARTIAL  = 8'h02;
   localparam logic [7:0] AD_UUID16_COMPLETE = 8'h03;
   localparam logic [7:0] AD_SERVICE_DATA16  = 8'h16;
   localparam logic [7:0] AD_NAME_SHORT      = 8'h08;
   localparam logic [7:0] AD_NAME_COMPLETE   = 8'h09;

   logic [7:0] pos_ff, pos_in;
   logic [7:0] start_ff, start_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] low_ff, low_in;
   logic       pm_ff, pm_in;
   logic       rm_ff, rm_in;
   logic       pn_ff, pn_in;
   logic       rn_ff, rn_in;
   logic       stop_ff, stop_in;

   logic [7:0]  off;
   logic [15:0] uuid;
   logic        pm_tmp;
   logic        pn_tmp;

   assign off  = pos_ff - start_ff;
   assign uuid = {ad_byte, low_ff};

   always_comb begin
      pos_in   = pos_ff;
      start_in = start_ff;
      len_in   = len_ff;
      type_in  = type_ff;
      low_in   = low_ff;
      pm_in    = pm_ff;
      rm_in    = rm_ff;
      pn_in    = pn_ff;
      rn_in    = rn_ff;
      stop_in  = stop_ff;
      pm_tmp   = pm_ff;
      pn_tmp   = pn_ff;

      if (step && !stop_ff) begin
         if (pos_ff >= 8'(MAX_REPORT_BYTES)) begin
            stop_in = 1'b1;
         end else if (off == 8'd0) begin
            len_in = ad_byte;
            pm_in  = 1'b0;
            pn_in  = 1'b0;
            if (ad_byte == 8'd0) begin
               stop_in = 1'b1;
            end
         end else begin
            if (off == 8'd1) begin
               type_in = ad_byte;
               if (ad_byte inside {AD_NAME_SHORT, AD_NAME_COMPLETE}) begin
                  pn_tmp = 1'b1;
               end
            end else if (!off[0]) begin
               low_in = ad_byte;
            end else if (uuid == service_uuid) begin
               if (type_ff inside {AD_UUID16_PARTIAL, AD_UUID16_COMPLETE}) begin
                  pm_tmp = 1'b1;
               end
               if (type_ff == AD_SERVICE_DATA16 && off == 8'd3) begin
                  pm_tmp = 1'b1;
               end
            end
            pm_in = pm_tmp;
            pn_in = pn_tmp;
            // structure closes inside the report: fold its findings in
            if (off == len_ff) begin
               rm_in    = rm_ff | pm_tmp;
               rn_in    = rn_ff | pn_tmp;
               pm_in    = 1'b0;
               pn_in    = 1'b0;
               start_in = pos_ff + 8'd1;
            end
         end
      end

      if (step && pos_ff != 8'hFF) begin
         pos_in = pos_ff + 8'd1;
      end

      report_match = rm_in;
      report_named = rn_in;

      if (clear) begin
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
         type_in  = '0;
         low_in   = '0;
         pm_in    = 1'b0;
         rm_in    = 1'b0;
         pn_in    = 1'b0;
         rn_in    = 1'b0;
         stop_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         type_ff  <= '0;
         low_ff   <= '0;
         pm_ff    <= 1'b0;
         rm_ff    <= 1'b0;
         pn_ff    <= 1'b0;
         rn_ff    <= 1'b0;
         stop_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         low_ff   <= low_in;
         pm_ff    <= pm_in;
         rm_ff    <= rm_in;
         pn_ff    <= pn_in;
         rn_ff    <= rn_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

/* src/bleadv_ctrl.sv */
// Controller state machine: request acceptance, table scan sequencing, result hand-off.
// Depends on bleadv_pkg.
module bleadv_ctrl
   import bleadv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    opcode,
   input  logic          last_byte,
   input  dp_status_type status,
   output logic          req_ready,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (opcode)
                  OP_AD_BYTE: begin
                     cmd.parse = 1'b1;
                     if (last_byte) begin
                        cmd.finish = 1'b1;
                        state_in   = S_SCAN;
                     end
                  end
                  OP_EMPTY_REPORT: begin
                     cmd.finish = 1'b1;
                     cmd.empty  = 1'b1;
                     state_in   = S_SCAN;
                  end
                  OP_READ_ENTRY: begin
                     cmd.read_start = 1'b1;
                     state_in       = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!status.decide) begin
               cmd.scan_step = 1'b1;
            end else if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_READ: begin
            if (status.out_free) begin
               cmd.read_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

endmodule

/* src/bleadv_dp.sv */
// Datapath: parser, report context, device table memory, scan compare and result register.
// Depends on bleadv_pkg, bleadv_parse and bleadv_ram.
module bleadv_dp
   import bleadv_pkg::*;
#(
   parameter int MAX_DEVICES = MAX_DEVICES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  req_type       req_payload,
   input  logic [23:0]   vendor_prefix,
   input  logic [15:0]   service_uuid,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_payload
);

   localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int CNT_W = $clog2(MAX_DEVICES + 1);
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

   // report context
   logic [47:0]       addr_ff;
   logic [1:0]        kind_ff;
   logic signed [7:0] signal_ff;
   logic [31:0]       tick_ff;
   logic              match_ff;
   logic              named_ff;
   logic [3:0]        read_idx_ff;

   // table scan
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              parse_match;
   logic              parse_named;
   logic              oui_hit;
   logic              issue;
   logic              hit;
   logic              out_free;
   logic              read_valid;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   entry_type         ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   entry_type         ram_rd_data;

   entry_type         upd_entry;
   entry_type         new_entry;

   bleadv_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (cmd.parse),
      .clear        (cmd.finish),
      .ad_byte      (req_payload.ad_byte),
      .service_uuid (service_uuid),
      .report_match (parse_match),
      .report_named (parse_named)
   );

   bleadv_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_DEVICES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign oui_hit    = (req_payload.device_address[47:24] == vendor_prefix);
   assign issue      = (scan_ff < count_ff);
   assign hit        = match_ff && cmp_valid_ff && (ram_rd_data.address == addr_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign read_valid = (CMP_W'(read_idx_ff) < CMP_W'(count_ff));

   assign status.decide   = !match_ff || hit || !issue;
   assign status.out_free = out_free;

   assign ram_rd_en   = cmd.read_start || (cmd.scan_step && issue);
   assign ram_rd_addr = cmd.read_start ? IDX_W'(req_payload.read_index) : scan_ff[IDX_W-1:0];

   always_comb begin
      upd_entry        = ram_rd_data;
      upd_entry.signal = signal_ff;
      upd_entry.last   = tick_ff;
      if (ram_rd_data.hits != 32'hFFFF_FFFF) begin
         upd_entry.hits = ram_rd_data.hits + 32'd1;
      end

      new_entry.address = addr_ff;
      new_entry.kind    = kind_ff;
      new_entry.signal  = signal_ff;
      new_entry.first   = tick_ff;
      new_entry.last    = tick_ff;
      new_entry.hits    = 32'd1;
      new_entry.named   = named_ff;
   end

   always_comb begin
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cmp_idx_ff;
      ram_wr_data  = upd_entry;

      if (cmd.finish) begin
         scan_in      = '0;
         cmp_valid_in = 1'b0;
      end

      if (cmd.scan_step) begin
         cmp_valid_in = issue;
         cmp_idx_in   = scan_ff[IDX_W-1:0];
         if (issue) begin
            scan_in = scan_ff + CNT_W'(1);
         end
      end

      if (cmd.commit) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.entry_count = 5'(count_ff);
         if (!match_ff) begin
            rsp_in.status = RSP_NO_MATCH;
         end else if (hit) begin
            ram_wr_en              = 1'b1;
            rsp_in.status          = RSP_UPDATED;
            rsp_in.entry_index     = 4'(cmp_idx_ff);
            rsp_in.entry_address   = upd_entry.address;
            rsp_in.entry_addr_kind = upd_entry.kind;
            rsp_in.entry_signal    = upd_entry.signal;
            rsp_in.added_tick      = upd_entry.first;
            rsp_in.latest_tick     = upd_entry.last;
            rsp_in.hits            = upd_entry.hits;
            rsp_in.named           = upd_entry.named;
         end else if (count_ff < CNT_W'(MAX_DEVICES)) begin
            ram_wr_en              = 1'b1;
            ram_wr_addr            = count_ff[IDX_W-1:0];
            ram_wr_data            = new_entry;
            count_in               = count_ff + CNT_W'(1);
            rsp_in.status          = RSP_ADDED;
            rsp_in.entry_index     = 4'(count_ff);
            rsp_in.entry_count     = 5'(count_in);
            rsp_in.entry_address   = new_entry.address;
            rsp_in.entry_addr_kind = new_entry.kind;
            rsp_in.entry_signal    = new_entry.signal;
            rsp_in.added_tick      = new_entry.first;
            rsp_in.latest_tick     = new_entry.last;
            rsp_in.hits            = new_entry.hits;
            rsp_in.named           = new_entry.named;
         end else begin
            rsp_in.status = RSP_TABLE_FULL;
         end
      end

      if (cmd.read_done) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.status      = RSP_READ_DATA;
         rsp_in.entry_index = read_idx_ff;
         rsp_in.entry_count = 5'(count_ff);
         if (read_valid) begin
            rsp_in.entry_address   = ram_rd_data.address;
            rsp_in.entry_addr_kind = ram_rd_data.kind;
            rsp_in.entry_signal    = ram_rd_data.signal;
            rsp_in.added_tick      = ram_rd_data.first;
            rsp_in.latest_tick     = ram_rd_data.last;
            rsp_in.hits            = ram_rd_data.hits;
            rsp_in.named           = ram_rd_data.named;
         end
      end
   end

   // payload captures, scan position and result data, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         addr_ff   <= req_payload.device_address;
         kind_ff   <= req_payload.addr_kind;
         signal_ff <= req_payload.signal_level;
         tick_ff   <= req_payload.now_tick;
         match_ff  <= oui_hit || (!cmd.empty && parse_match);
         named_ff  <= !cmd.empty && parse_named;
      end
      if (cmd.read_start) begin
         read_idx_ff <= req_payload.read_index;
      end
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* src/ble_adv_filter_device_table_top.sv */
// Top level of the BLE advertising filter with device table: register port and wiring.
// Depends on bleadv_pkg, bleadv_ctrl and bleadv_dp.
//
// Feed advertising reports one AD byte per item (opcode 0, last_byte marks the final
// byte), or a report with no AD bytes as a single opcode 1 item; opcode 2 reads one
// table entry and opcode 3 is ignored. AD bytes that are not the last of a report are
// taken one per clock and produce no result. A matching report end scans the device table,
// which sits in a single-read-port memory with a registered read, one entry per cycle,
// before the next item is taken, and always yields one result. Results leave through
// an output register, so a waiting result does not hold back AD bytes. The table
// needs no clearing after reset: only entries below the device count are ever used.
// Write vendor_prefix (address 0) and service_uuid (address 4) only while no report
// is in progress and no result is pending.
module ble_adv_filter_device_table_top
   import bleadv_pkg::*;
#(
   parameter int MAX_DEVICES = MAX_DEVICES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,

   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,

   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // register index is address bit 2
   localparam logic REG_VENDOR_PREFIX = 1'b0;
   localparam logic REG_SERVICE_UUID  = 1'b1;

   logic [23:0]   prefix_ff;
   logic [15:0]   uuid_ff;
   logic          csr_write;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // no wait states on the register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= VENDOR_PREFIX_RESET;
         uuid_ff   <= SERVICE_UUID_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_VENDOR_PREFIX: prefix_ff <= csr_pwdata[23:0];
            REG_SERVICE_UUID:  uuid_ff   <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // read back zero-extended register contents
   always_comb begin
      case (csr_paddr[2])
         REG_VENDOR_PREFIX: csr_prdata = {8'd0, prefix_ff};
         REG_SERVICE_UUID:  csr_prdata = {16'd0, uuid_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // sequence acceptance, scan and result hand-off
   bleadv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .opcode    (req_payload.opcode),
      .last_byte (req_payload.last_byte),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // parse, hold the table, build results
   bleadv_dp #(
      .MAX_DEVICES (MAX_DEVICES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_payload   (req_payload),
      .vendor_prefix (prefix_ff),
      .service_uuid  (uuid_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

endmodule

/* verif/ble_adv_filter_device_table_top_tb.sv */
// Self-checking testbench for ble_adv_filter_device_table_top: drives AD-byte, empty-report
// and table-read items, predicts every result in step, and compares field by field.
// Depends on bleadv_pkg and the ble_adv_filter_device_table_top RTL.
module ble_adv_filter_device_table_top_tb
   import bleadv_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH   = MAX_DEVICES_DEFAULT;
   // a report end scans up to TABLE_DEPTH entries
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
   localparam int LONG_HOLD     = 300;
   localparam int STALL_LIMIT   = 5000;
   localparam int SHOWN_ERRORS  = 10;

   localparam logic [1:0] OP_IGNORED = 2'd3;

   localparam logic [2:0] CSR_VENDOR_PREFIX = 3'd0;
   localparam logic [2:0] CSR_SERVICE_UUID  = 3'd4;

   // AD structure types; the filter looks at all but AD_FLAGS
   localparam bit [7:0] AD_FLAGS        = 8'h01;
   localparam bit [7:0] AD_UUID16_PART  = 8'h02;
   localparam bit [7:0] AD_UUID16_FULL  = 8'h03;
   localparam bit [7:0] AD_NAME_SHORT   = 8'h08;
   localparam bit [7:0] AD_NAME_FULL    = 8'h09;
   localparam bit [7:0] AD_SERVICE_DATA = 8'h16;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ble_adv_filter_device_table_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 12 ns period
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ------------------------------------------------------------------
   // Predictor state: register copies, AD walk state and the device table
   // ------------------------------------------------------------------
   typedef struct {
      bit [47:0] address;
      bit [1:0]  kind;
      bit [7:0]  signal;
      bit [31:0] first;
      bit [31:0] last;
      bit [31:0] hits;
      bit        named;
   } dev_row_t;

   bit [23:0] model_prefix = VENDOR_PREFIX_RESET;
   bit [15:0] model_uuid   = SERVICE_UUID_RESET;
   bit [7:0]  walk_pos, seg_start, seg_len, seg_type, uuid_lo;
   bit        seg_uuid_hit, report_uuid_hit, seg_name, report_has_name, walk_stopped;
   bit [4:0]  dev_count;
   dev_row_t  dev_table [TABLE_DEPTH];

   rsp_type   awaited_outcomes [$];

   // stimulus bookkeeping
   bit [7:0]  report_bytes [$];
   bit [47:0] known_addrs [$];
   int        items_counted;
   int        send_idle_pct;
   int        recv_idle_pct;
   bit        hold_pending;
   int        hold_left;
   int        failures;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic void reset_walk();
      walk_pos        = '0;
      seg_start       = '0;
      seg_len         = '0;
      seg_type        = '0;
      uuid_lo         = '0;
      seg_uuid_hit    = 1'b0;
      report_uuid_hit = 1'b0;
      seg_name        = 1'b0;
      report_has_name = 1'b0;
      walk_stopped    = 1'b0;
   endfunction

   function automatic rsp_type entry_outcome(bit [2:0] st, int slot, bit valid);
      rsp_type r;
      r             = '0;
      r.status      = st;
      r.entry_index = slot[3:0];
      r.entry_count = dev_count;
      if (valid && slot < TABLE_DEPTH) begin
         r.entry_address   = dev_table[slot].address;
         r.entry_addr_kind = dev_table[slot].kind;
         r.entry_signal    = dev_table[slot].signal;
         r.added_tick      = dev_table[slot].first;
         r.latest_tick     = dev_table[slot].last;
         r.hits            = dev_table[slot].hits;
         r.named           = dev_table[slot].named;
      end
      return r;
   endfunction

   // Walk one AD byte through the length-type structure parser.
   function automatic void walk_ad_byte(bit [7:0] b);
      bit [7:0] off;
      if (!walk_stopped) begin
         if (walk_pos >= MAX_REPORT_BYTES) begin
            walk_stopped = 1'b1;
         end else begin
            off = walk_pos - seg_start;
            if (off == 8'd0) begin
               seg_len      = b;
               seg_uuid_hit = 1'b0;
               seg_name     = 1'b0;
               if (b == 8'd0) walk_stopped = 1'b1;
            end else begin
               if (off == 8'd1) begin
                  seg_type = b;
                  if (b == AD_NAME_SHORT || b == AD_NAME_FULL) seg_name = 1'b1;
               end else if (!off[0]) begin
                  uuid_lo = b;
               end else if ({b, uuid_lo} == model_uuid) begin
                  if (seg_type == AD_UUID16_PART || seg_type == AD_UUID16_FULL)
                     seg_uuid_hit = 1'b1;
                  if (seg_type == AD_SERVICE_DATA && off == 8'd3) seg_uuid_hit = 1'b1;
               end
               // a structure counts only once its last byte is inside the report
               if (off == seg_len) begin
                  if (seg_uuid_hit) report_uuid_hit = 1'b1;
                  if (seg_name) report_has_name = 1'b1;
                  seg_uuid_hit = 1'b0;
                  seg_name     = 1'b0;
                  seg_start    = walk_pos + 8'd1;
               end
            end
         end
      end
      if (walk_pos != 8'hFF) walk_pos++;
   endfunction

   function automatic rsp_type close_report(req_type it);
      bit hit;
      bit named_now;
      int slot;
      hit       = (it.device_address[47:24] == model_prefix) || report_uuid_hit;
      named_now = report_has_name;
      reset_walk();
      if (!hit) return entry_outcome(RSP_NO_MATCH, 0, 1'b0);
      for (slot = 0; slot < int'(dev_count); slot++) begin
         if (dev_table[slot].address == it.device_address) begin
            dev_table[slot].signal = it.signal_level;
            dev_table[slot].last   = it.now_tick;
            if (dev_table[slot].hits != 32'hFFFF_FFFF) dev_table[slot].hits++;
            return entry_outcome(RSP_UPDATED, slot, 1'b1);
         end
      end
      if (dev_count < TABLE_DEPTH) begin
         slot = dev_count;
         dev_table[slot].address = it.device_address;
         dev_table[slot].kind    = it.addr_kind;
         dev_table[slot].signal  = it.signal_level;
         dev_table[slot].first   = it.now_tick;
         dev_table[slot].last    = it.now_tick;
         dev_table[slot].hits    = 32'd1;
         dev_table[slot].named   = named_now;
         dev_count++;
         return entry_outcome(RSP_ADDED, slot, 1'b1);
      end
      return entry_outcome(RSP_TABLE_FULL, 0, 1'b0);
   endfunction

   function automatic void predict_filter_outcome(req_type it);
      case (it.opcode)
         OP_AD_BYTE: begin
            walk_ad_byte(it.ad_byte);
            if (it.last_byte) awaited_outcomes.push_back(close_report(it));
         end
         OP_EMPTY_REPORT: begin
            // drop any partial report; only the OUI can match
            reset_walk();
            awaited_outcomes.push_back(close_report(it));
         end
         OP_READ_ENTRY: begin
            awaited_outcomes.push_back(entry_outcome(RSP_READ_DATA, int'(it.read_index),
                                                     it.read_index < dev_count));
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   function automatic string outcome_text(rsp_type r);
      return $sformatf({"status=%0d index=%0d count=%0d addr=%h kind=%0d signal=%0d ",
                        "first=%h last=%h hits=%h named=%0d"},
                       r.status, r.entry_index, r.entry_count, r.entry_address,
                       r.entry_addr_kind, r.entry_signal, r.added_tick, r.latest_tick,
                       r.hits, r.named);
   endfunction

   function automatic bit same_outcome(rsp_type a, rsp_type b);
      return a.status === b.status && a.entry_index === b.entry_index &&
             a.entry_count === b.entry_count && a.entry_address === b.entry_address &&
             a.entry_addr_kind === b.entry_addr_kind && a.entry_signal === b.entry_signal &&
             a.added_tick === b.added_tick && a.latest_tick === b.latest_tick &&
             a.hits === b.hits && a.named === b.named;
   endfunction

   function automatic void note_failure(string what);
      failures++;
      if (failures <= SHOWN_ERRORS) $display("ERROR at %0t: %s", $realtime, what);
   endfunction

   // Check the oldest expectation against each result taken, then feed each
   // accepted item to the predictor. One process keeps the queue order fixed.
   always @(posedge clock) begin : observe
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               note_failure({"result with none expected: ", outcome_text(rsp_payload)});
            end else begin
               want = awaited_outcomes.pop_front();
               if (!same_outcome(want, rsp_payload))
                  note_failure({"result mismatch\n  expected ", outcome_text(want),
                                "\n  actual   ", outcome_text(rsp_payload)});
            end
         end
         if (req_valid && req_ready) predict_filter_outcome(req_payload);
      end
   end

   // Watchdog: end the run once nothing moves on either channel for too long.
   always @(posedge clock) begin : watchdog
      int stall_count;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count = 0;
      end else begin
         stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
            $display("ble_adv_filter_device_table_top_tb failed");
            $finish;
         end
      end
   end

   // Receiver: random stalls, or a long hold-off counted here when requested.
   always @(negedge clock) begin : drive_result_ready
      if (hold_pending) begin
         hold_left    = LONG_HOLD;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   task automatic check_register(logic [2:0] addr);
      bit [31:0] want;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      want = (addr == CSR_VENDOR_PREFIX) ? {8'h00, model_prefix} : {16'h0000, model_uuid};
      if (csr_prdata !== want)
         note_failure($sformatf("register %0d read: expected %h, actual %h",
                                addr, want, csr_prdata));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_register(logic [2:0] addr, bit [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == CSR_VENDOR_PREFIX) model_prefix = value[23:0];
      else model_uuid = value[15:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      check_register(addr);
   endtask

   // ------------------------------------------------------------------
   // Item sender and stimulus helpers
   // ------------------------------------------------------------------
   // Call at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      if (it.opcode != OP_IGNORED) items_counted++;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid, wait for every expected result, then let a report-end scan finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic req_type random_item(logic [1:0] op);
      req_type   it;
      bit [63:0] w;
      w                 = {$urandom, $urandom};
      it.opcode         = op;
      it.ad_byte        = 8'($urandom);
      it.last_byte      = 1'($urandom);
      it.device_address = w[47:0];
      it.addr_kind      = 2'($urandom);
      it.signal_level   = 8'($urandom);
      it.now_tick       = $urandom;
      it.read_index     = 4'($urandom);
      return it;
   endfunction

   // Mix of devices seen before (updates), OUI devices and random ones.
   function automatic bit [47:0] pick_address();
      bit [63:0] w;
      bit [47:0] a;
      if (known_addrs.size() > 0 && $urandom_range(99) < 40)
         return known_addrs[$urandom_range(known_addrs.size() - 1)];
      w = {$urandom, $urandom};
      a = w[47:0];
      if ($urandom_range(1) == 1) a[47:24] = model_prefix;
      if (known_addrs.size() < 32) known_addrs.push_back(a);
      return a;
   endfunction

   function automatic bit [15:0] pick_uuid(int hit_pct);
      if ($urandom_range(99) < hit_pct) return model_uuid;
      return 16'($urandom);
   endfunction

   function automatic void add_structure();
      bit [15:0] u;
      int        n;
      case ($urandom_range(4))
         0: begin
            report_bytes.push_back(8'd2);
            report_bytes.push_back(AD_FLAGS);
            report_bytes.push_back(8'($urandom));
         end
         1: begin
            n = $urandom_range(1, 3);
            report_bytes.push_back(8'(1 + 2 * n));
            report_bytes.push_back($urandom_range(1) ? AD_UUID16_PART : AD_UUID16_FULL);
            repeat (n) begin
               u = pick_uuid(40);
               report_bytes.push_back(u[7:0]);
               report_bytes.push_back(u[15:8]);
            end
         end
         2: begin
            n = $urandom_range(0, 3);
            u = pick_uuid(60);
            report_bytes.push_back(8'(3 + n));
            report_bytes.push_back(AD_SERVICE_DATA);
            report_bytes.push_back(u[7:0]);
            report_bytes.push_back(u[15:8]);
            repeat (n) report_bytes.push_back(8'($urandom));
         end
         3: begin
            n = $urandom_range(1, 5);
            report_bytes.push_back(8'(1 + n));
            report_bytes.push_back($urandom_range(1) ? AD_NAME_SHORT : AD_NAME_FULL);
            repeat (n) report_bytes.push_back(8'($urandom_range(32, 126)));
         end
         default: begin
            n = $urandom_range(0, 4);
            report_bytes.push_back(8'(1 + n));
            report_bytes.push_back(8'($urandom));
            repeat (n) report_bytes.push_back(8'($urandom));
         end
      endcase
   endfunction

   // Mostly well-formed reports; some long, some broken, some plain noise.
   function automatic void compose_report();
      int shape;
      int target;
      int kept;
      report_bytes.delete();
      shape = $urandom_range(99);
      if (shape < 90) begin
         target = (shape >= 65 && shape < 75) ?
                  $urandom_range(MAX_REPORT_BYTES + 1, 45) : $urandom_range(3, MAX_REPORT_BYTES);
         do begin
            kept = report_bytes.size();
            add_structure();
         end while (report_bytes.size() < target);
         // keep ordinary reports within the walk limit
         if ((shape < 65 || shape >= 75) && report_bytes.size() > MAX_REPORT_BYTES)
            while (report_bytes.size() > kept) void'(report_bytes.pop_back());
         if (shape >= 75) begin
            if ($urandom_range(1) == 1)
               report_bytes.insert($urandom_range(report_bytes.size() - 1), 8'h00);
            else
               repeat ($urandom_range(1, 2))
                  if (report_bytes.size() > 1) void'(report_bytes.pop_back());
         end
      end else begin
         repeat ($urandom_range(1, 12)) report_bytes.push_back(8'($urandom));
      end
   endfunction

   task automatic send_side_item();
      req_type it;
      if ($urandom_range(2) == 0) begin
         it = random_item(OP_IGNORED);
      end else begin
         it = random_item(OP_READ_ENTRY);
         if (dev_count > 0 && $urandom_range(99) < 70)
            it.read_index = 4'($urandom_range(int'(dev_count) - 1));
      end
      send_item(it);
   endtask

   // Send report_bytes as AD-byte items; mark_last flags the final one.
   task automatic send_report(bit [47:0] addr, bit interleave, bit mark_last);
      req_type it;
      int      i;
      for (i = 0; i < report_bytes.size(); i++) begin
         if (interleave && $urandom_range(99) < 6) send_side_item();
         it                = random_item(OP_AD_BYTE);
         it.ad_byte        = report_bytes[i];
         it.last_byte      = mark_last && (i == report_bytes.size() - 1);
         it.device_address = addr;
         send_item(it);
      end
   endtask

   function automatic req_type empty_report(bit [47:0] addr);
      req_type it;
      it                = random_item(OP_EMPTY_REPORT);
      it.device_address = addr;
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_register_access();
      check_register(CSR_VENDOR_PREFIX);
      check_register(CSR_SERVICE_UUID);
   endtask

   task automatic test_directed_cases();
      req_type it;
      send_idle_pct = 28;
      recv_idle_pct = 54;
      // read on an empty table
      it = random_item(OP_READ_ENTRY);
      it.read_index = 4'd0;
      send_item(it);
      // OUI match with extreme field values adds a device
      it              = empty_report({VENDOR_PREFIX_RESET, 24'hFF_FFFF});
      it.addr_kind    = 2'd3;
      it.signal_level = -8'sd128;
      it.now_tick     = 32'hFFFF_FFFF;
      send_item(it);
      // same device again updates signal, last_seen and hits only
      it              = empty_report({VENDOR_PREFIX_RESET, 24'hFF_FFFF});
      it.addr_kind    = 2'd0;
      it.signal_level = 8'sd127;
      it.now_tick     = 32'd0;
      send_item(it);
      send_item(random_item(OP_IGNORED));
      send_item(empty_report(48'h0));
      it = random_item(OP_READ_ENTRY);
      it.read_index = 4'd0;
      send_item(it);
      it.read_index = 4'd15;
      send_item(it);
      // name structure plus service data carrying the UUID
      report_bytes = '{8'h02, AD_NAME_FULL, 8'h41, 8'h03, AD_SERVICE_DATA,
                       SERVICE_UUID_RESET[7:0], SERVICE_UUID_RESET[15:8]};
      send_report(48'hFFFF_FFFF_FFFF, 1'b0, 1'b1);
      // UUID list still open at report end: its match is dropped
      report_bytes = '{8'h04, AD_UUID16_FULL, SERVICE_UUID_RESET[7:0], SERVICE_UUID_RESET[15:8]};
      send_report(48'h1234_5678_9ABC, 1'b0, 1'b1);
      // zero length stops the walk before the UUID list
      report_bytes = '{8'h00, 8'h03, AD_UUID16_PART, SERVICE_UUID_RESET[7:0],
                       SERVICE_UUID_RESET[15:8]};
      send_report(48'h1234_5678_9ABC, 1'b0, 1'b1);
   endtask

   task automatic test_random_reports(bit [23:0] prefix, bit [15:0] uuid,
                                      int send_pct, int recv_pct, int item_goal);
      int      start;
      int      r;
      bit [47:0] addr;
      wait_idle();
      write_register(CSR_VENDOR_PREFIX, {8'h00, prefix});
      write_register(CSR_SERVICE_UUID, {16'h0000, uuid});
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = items_counted;
      while (items_counted - start < item_goal) begin
         r    = $urandom_range(99);
         addr = pick_address();
         if (r < 12) begin
            send_side_item();
         end else if (r < 22) begin
            send_item(empty_report(addr));
         end else if (r < 28) begin
            // report left without its last-byte mark, then an empty report
            compose_report();
            send_report(addr, 1'b1, 1'b0);
            send_item(empty_report(pick_address()));
         end else begin
            compose_report();
            send_report(addr, 1'b1, 1'b1);
         end
      end
   endtask

   // Hold the result side off while report ends keep coming, then drain.
   task automatic test_output_backpressure();
      hold_pending = 1'b1;
      repeat (4) begin
         compose_report();
         send_report(pick_address(), 1'b0, 1'b1);
         send_item(empty_report(pick_address()));
      end
      wait_idle();
   endtask

   task automatic test_table_fill();
      bit [63:0] w;
      int        guard;
      guard = 0;
      while (dev_count < TABLE_DEPTH && guard < 40) begin
         w = {$urandom, $urandom};
         send_item(empty_report({model_prefix, w[23:0]}));
         guard++;
      end
      // table is full now: a new device is dropped
      w = {$urandom, $urandom};
      send_item(empty_report({model_prefix, w[23:0]}));
      wait_idle();
   endtask

   // Report far past the walk limit, so the byte position saturates.
   task automatic test_long_report();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      report_bytes.delete();
      report_bytes.push_back(8'd2);
      report_bytes.push_back(AD_FLAGS);
      report_bytes.push_back(8'h06);
      repeat (254) report_bytes.push_back(8'($urandom));
      send_report(pick_address(), 1'b0, 1'b1);
      wait_idle();
   endtask

   task automatic test_read_back_table();
      req_type it;
      int      i;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         it            = random_item(OP_READ_ENTRY);
         it.read_index = 4'(i);
         send_item(it);
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      reset_walk();
      dev_count = '0;

      test_register_access();
      test_directed_cases();
      test_random_reports(VENDOR_PREFIX_RESET, SERVICE_UUID_RESET, 28, 54, 40);
      test_random_reports(24'h00_0000, 16'h0000, 54, 28, 40);
      test_output_backpressure();
      test_table_fill();
      test_long_report();
      test_random_reports(24'hFF_FFFF, 16'hFFFF, 0, 0, 40);
      test_random_reports(24'($urandom), 16'($urandom), 0, 0, 40);
      test_read_back_table();

      // wait out every result and a last scan's worth of cycles
      wait_idle();
      if (failures == 0) begin
         $display("ble_adv_filter_device_table_top_tb passed");
      end else begin
         $display("ble_adv_filter_device_table_top_tb failed");
      end
      $finish;
   end

endmodule
